/* hdl/masked_byte_pattern_scanner_macros.svh */
// assertion macros for the masked byte pattern scanner
`ifndef MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define MBPS_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("mbps assertion failed");

// next-cycle implication, checked out of reset
`define MBPS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("mbps assertion failed");

`else

`define MBPS_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define MBPS_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

/* hdl/mbps_pkg.sv */
// shared constants and types for the masked byte pattern scanner
package mbps_pkg;

    // window depth
    localparam int MAX_PATTERN  = 32;
    // pattern storage is four 64-bit words
    localparam int NUM_PAT_BYTES = 32;
    localparam int USABLE_LEN   = (MAX_PATTERN < NUM_PAT_BYTES) ? MAX_PATTERN : NUM_PAT_BYTES;
    localparam int SEEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int PAT_IDX_W    = $clog2(NUM_PAT_BYTES);

    localparam int LEN_W        = 6;
    localparam int MASK_W       = 32;
    localparam int OFFSET_W     = 32;
    localparam int ADDR_W       = 64;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_0_7    = 3'd0,
        CFG_PATTERN_8_15   = 3'd1,
        CFG_PATTERN_16_23  = 3'd2,
        CFG_PATTERN_24_31  = 3'd3,
        CFG_COMPARE_MASK   = 3'd4,
        CFG_PATTERN_LENGTH = 3'd5,
        CFG_RESULT_OFFSET  = 3'd6
    } cfg_index_t;

endpackage

/* hdl/masked_byte_pattern_scanner.sv */
// top level of the masked byte pattern scanner
//
// Scans a byte stream, one byte with its address per request, for a pattern of
// up to 32 bytes in which set mask bits mark the compared positions and clear bits
// mark wildcards; buffer_end closes a buffer. The first match in a buffer gives
// found = 1 and the match start address plus the signed result offset; a buffer
// that ends without one gives found = 0. One request is taken every cycle while
// in_stall is low; a result passes through the input register, then the result
// register. The 32 masked byte comparators and the 64-bit address add share the
// single stage between those two registers. The in-stage window and match state
// advance only when that stage moves, so a result held on out_stall stops the input
// side once the input register is also full. Pattern registers may be written while
// no request is in flight; the pattern alignment they feed is registered.
`include "masked_byte_pattern_scanner_macros.svh"

module masked_byte_pattern_scanner (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write_en,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic [mbps_pkg::ADDR_W-1:0]     byte_address,
    input  logic                            buffer_end,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [mbps_pkg::ADDR_W-1:0]     match_address
);

    // configuration
    logic [63:0]                       pattern_word_reg [4];
    logic [mbps_pkg::MASK_W-1:0]       compare_mask_reg;
    logic [mbps_pkg::LEN_W-1:0]        pattern_length_reg;
    logic [mbps_pkg::OFFSET_W-1:0]     result_offset_reg;

    // pattern aligned to window positions, newest byte at position 0
    logic [7:0]                        align_pat_reg  [mbps_pkg::USABLE_LEN];
    logic [7:0]                        align_pat_next [mbps_pkg::USABLE_LEN];
    logic [mbps_pkg::USABLE_LEN-1:0]   align_mask_reg;
    logic [mbps_pkg::USABLE_LEN-1:0]   align_mask_next;
    logic                              len_ok_reg;
    logic                              len_ok_next;
    logic [mbps_pkg::ADDR_W-1:0]       addr_adj_reg;
    logic [mbps_pkg::ADDR_W-1:0]       addr_adj_next;

    // input stage
    logic                              s1_valid_reg;
    logic [mbps_pkg::ADDR_W-1:0]       s1_addr_reg;
    logic                              s1_last_reg;
    logic                              restart_reg;
    logic [7:0]                        window_reg  [mbps_pkg::MAX_PATTERN];
    logic [7:0]                        window_next [mbps_pkg::MAX_PATTERN];
    logic [mbps_pkg::SEEN_W-1:0]       seen_reg;
    logic [mbps_pkg::SEEN_W-1:0]       seen_next;
    logic                              matched_reg;
    logic                              matched_next;

    // result stage
    logic                              out_valid_reg;
    logic                              found_reg;
    logic [mbps_pkg::ADDR_W-1:0]       match_address_reg;

    logic                              out_adv;
    logic                              s1_adv;
    logic                              accept;
    logic                              bytes_equal;
    logic                              hit;
    logic                              produce;
    logic [255:0]                      pattern_flat;

    // the result register may load only when it is empty or being taken
    assign out_adv  = !out_valid_reg || !out_stall;
    assign s1_adv   = !s1_valid_reg || out_adv;
    assign in_stall = !s1_adv;
    assign accept   = in_valid && s1_adv;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pattern_word_reg[i] <= '0;
            end
            compare_mask_reg   <= '0;
            pattern_length_reg <= '0;
            result_offset_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (mbps_pkg::cfg_index_t'(cfg_index))
                mbps_pkg::CFG_PATTERN_0_7:    pattern_word_reg[0] <= cfg_data;
                mbps_pkg::CFG_PATTERN_8_15:   pattern_word_reg[1] <= cfg_data;
                mbps_pkg::CFG_PATTERN_16_23:  pattern_word_reg[2] <= cfg_data;
                mbps_pkg::CFG_PATTERN_24_31:  pattern_word_reg[3] <= cfg_data;
                mbps_pkg::CFG_COMPARE_MASK:
                    compare_mask_reg <= cfg_data[mbps_pkg::MASK_W-1:0];
                mbps_pkg::CFG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[mbps_pkg::LEN_W-1:0];
                mbps_pkg::CFG_RESULT_OFFSET:
                    result_offset_reg <= cfg_data[mbps_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    assign pattern_flat = {pattern_word_reg[3], pattern_word_reg[2],
                           pattern_word_reg[1], pattern_word_reg[0]};

    // window position k compares against pattern byte length-1-k
    always_comb
    begin
        logic [mbps_pkg::LEN_W-1:0]     idx;
        logic [mbps_pkg::PAT_IDX_W-1:0] sel;
        for (int k = 0; k < mbps_pkg::USABLE_LEN; k++)
        begin
            idx = pattern_length_reg - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(k);
            sel = idx[mbps_pkg::PAT_IDX_W-1:0];
            align_pat_next[k] = pattern_flat[sel*8 +: 8];
            if (k < int'(pattern_length_reg))
            begin
                align_mask_next[k] = compare_mask_reg[sel];
            end
            else
            begin
                align_mask_next[k] = 1'b0;
            end
        end
        len_ok_next = (pattern_length_reg != '0) &&
                      (int'(pattern_length_reg) <= mbps_pkg::USABLE_LEN);
        addr_adj_next =
            {{(mbps_pkg::ADDR_W-mbps_pkg::OFFSET_W){result_offset_reg[mbps_pkg::OFFSET_W-1]}},
             result_offset_reg}
            - {{(mbps_pkg::ADDR_W-mbps_pkg::LEN_W){1'b0}},
               pattern_length_reg - mbps_pkg::LEN_W'(1)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mbps_pkg::USABLE_LEN; k++)
            begin
                align_pat_reg[k] <= '0;
            end
            align_mask_reg <= '0;
            len_ok_reg     <= 1'b0;
            addr_adj_reg   <= '0;
        end
        else
        begin
            align_pat_reg  <= align_pat_next;
            align_mask_reg <= align_mask_next;
            len_ok_reg     <= len_ok_next;
            addr_adj_reg   <= addr_adj_next;
        end
    end

    // window shift on accept, starting fresh after a buffer end
    always_comb
    begin
        window_next[0] = data_byte;
        for (int i = 1; i < mbps_pkg::MAX_PATTERN; i++)
        begin
            window_next[i] = restart_reg ? 8'd0 : window_reg[i-1];
        end
        if (restart_reg)
        begin
            seen_next = mbps_pkg::SEEN_W'(1);
        end
        else if (seen_reg < mbps_pkg::SEEN_W'(mbps_pkg::MAX_PATTERN))
        begin
            seen_next = seen_reg + mbps_pkg::SEEN_W'(1);
        end
        else
        begin
            seen_next = seen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            restart_reg  <= 1'b1;
            seen_reg     <= '0;
            for (int i = 0; i < mbps_pkg::MAX_PATTERN; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_valid;
            end
            if (accept)
            begin
                restart_reg <= buffer_end;
                seen_reg    <= seen_next;
                window_reg  <= window_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= byte_address;
            s1_last_reg <= buffer_end;
        end
    end

    // masked compare over the window
    always_comb
    begin
        bytes_equal = 1'b1;
        for (int k = 0; k < mbps_pkg::USABLE_LEN; k++)
        begin
            if (align_mask_reg[k] && (window_reg[k] != align_pat_reg[k]))
            begin
                bytes_equal = 1'b0;
            end
        end
    end

    assign hit = s1_valid_reg && !matched_reg && len_ok_reg && bytes_equal &&
                 (int'(seen_reg) >= int'(pattern_length_reg));
    assign produce = hit || (s1_valid_reg && s1_last_reg && !matched_reg);

    always_comb
    begin
        matched_next = matched_reg;
        if (s1_valid_reg)
        begin
            matched_next = s1_last_reg ? 1'b0 : (matched_reg || hit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            matched_reg   <= matched_next;
            out_valid_reg <= produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && produce)
        begin
            found_reg         <= hit;
            match_address_reg <= hit ? (s1_addr_reg + addr_adj_reg) : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = match_address_reg;

    `MBPS_ASSERT_IMPLY(a_not_found_zero, clk, rst_n, out_valid && !found, match_address == '0)
    `MBPS_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg && out_stall)
    `MBPS_ASSERT_NEXT(a_buffer_end_clears, clk, rst_n, s1_valid_reg && s1_adv && s1_last_reg, !matched_reg)
    `MBPS_ASSERT_IMPLY(a_seen_bound, clk, rst_n, s1_valid_reg, seen_reg <= mbps_pkg::SEEN_W'(mbps_pkg::MAX_PATTERN))

endmodule
